// ===== rtl/bst_pkg.sv =====
package bst_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int NAME_BYTES  = 32;
	localparam int SLOT_W      = $clog2(MAX_ENTRIES);
	localparam int NIDX_W      = $clog2(NAME_BYTES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int NLEN_W      = 5;
	localparam int ADDR_W      = 48;
	localparam int NADDR_W     = SLOT_W + NIDX_W;
	localparam int QUEUE_DEPTH = 2;
	localparam int IN_DATA_W   = 96;
	localparam int OUT_DATA_W  = 96;

	// longest stored name, one byte short of the slot
	localparam logic [NLEN_W-1:0] NAME_MAX = NLEN_W'(NAME_BYTES - 1);

	// AD structure types that carry a local name
	localparam logic [7:0] AD_SHORT_NAME    = 8'h08;
	localparam logic [7:0] AD_COMPLETE_NAME = 8'h09;

	localparam logic MODE_REPORT = 1'b0;
	localparam logic MODE_READ   = 1'b1;

	typedef enum logic [1:0] {
		ST_UPDATED = 2'd0,
		ST_ADDED   = 2'd1,
		ST_DROPPED = 2'd2
	} status_t;

	// one queued item, with the front's position tag
	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        addr_kind;
		logic signed [7:0] rssi;
		logic [7:0]        plen;
		logic [7:0]        pbyte;
		logic              last;
		logic [3:0]        rslot;
		logic [4:0]        ridx;
		logic [7:0]        pos;
		logic              first;
	} item_t;

	typedef struct packed {
		status_t           status;
		logic [3:0]        slot;
		logic [4:0]        total;
		logic              named;
		logic [NLEN_W-1:0] nlen;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        addr_kind;
		logic signed [7:0] rssi;
		logic [7:0]        nbyte;
	} result_t;

	// queue to back end handshake
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

endpackage

// ===== rtl/bst_front.sv =====
module bst_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [bst_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input  logic                             s_axis_tuser,
	input  logic                             s_axis_tlast,
	input  logic                             q_full,
	output logic                             push,
	output bst_pkg::item_t                   push_item
);

	logic [7:0] pos_q;

	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && s_axis_tready;

	always_comb begin
		push_item           = '0;
		push_item.mode      = s_axis_tuser;
		push_item.addr      = s_axis_tdata[47:0];
		push_item.addr_kind = s_axis_tdata[55:48];
		push_item.rssi      = s_axis_tdata[63:56];
		push_item.plen      = s_axis_tdata[71:64];
		push_item.pbyte     = s_axis_tdata[79:72];
		push_item.rslot     = s_axis_tdata[83:80];
		push_item.ridx      = s_axis_tdata[88:84];
		push_item.last      = s_axis_tlast;
		push_item.pos       = pos_q;
		push_item.first     = (s_axis_tuser == bst_pkg::MODE_REPORT) && (pos_q == 8'd0);
	end

	// byte position within the report; read-backs leave it alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push && s_axis_tuser == bst_pkg::MODE_REPORT) begin
			if (s_axis_tlast) begin
				pos_q <= '0;
			end else if (pos_q != 8'hFF) begin
				pos_q <= pos_q + 8'd1;
			end
		end
	end

endmodule

// ===== rtl/bst_queue.sv =====
module bst_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bst_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output bst_pkg::head_t head
);

	localparam int PTR_W = (bst_pkg::QUEUE_DEPTH > 1) ? $clog2(bst_pkg::QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(bst_pkg::QUEUE_DEPTH + 1);

	bst_pkg::item_t         slot_q [bst_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [FILL_W-1:0]      fill_q;

	assign full       = (fill_q == FILL_W'(bst_pkg::QUEUE_DEPTH));
	assign head.valid = (fill_q != '0);
	assign head.item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(bst_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(bst_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/bst_back.sv =====
module bst_back (
	input  logic             clk,
	input  logic             arst_n,
	input  bst_pkg::head_t   head,
	output logic             pop,
	output logic             res_valid,
	input  logic             res_ready,
	output bst_pkg::result_t res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_LOOKUP,
		S_PARSE,
		S_EMIT
	} st_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LEN,
		PH_TYPE,
		PH_NAME
	} ph_t;

	localparam int ME = bst_pkg::MAX_ENTRIES;
	localparam int SW = bst_pkg::SLOT_W;
	localparam int CW = bst_pkg::CNT_W;
	localparam int LW = bst_pkg::NLEN_W;

	st_t                         state_q;
	ph_t                         phase_q;
	bst_pkg::item_t              item_q;
	logic [ME-1:0]               match_q;
	logic [CW-1:0]               count_q;
	logic [7:0]                  sstart_q;
	logic [7:0]                  slen_q;
	logic [SW-1:0]               cur_q;
	bst_pkg::status_t            pend_q;
	logic                        named_q [ME];
	logic [LW-1:0]               nlen_q [ME];

	logic [bst_pkg::ADDR_W-1:0]  addr_q [ME];
	logic [7:0]                  kind_q [ME];
	logic [7:0]                  rssi_q [ME];

	logic [7:0]                  name_mem [ME * bst_pkg::NAME_BYTES];
	logic [7:0]                  mem_rd_q;

	// lookup
	logic                        hit;
	logic [SW-1:0]               hit_idx;
	logic                        lk_add;
	logic [SW-1:0]               add_idx;
	logic [ME-1:0]               match_d;

	// parse step
	ph_t                         ph_d;
	logic [7:0]                  sstart_d;
	logic [7:0]                  slen_d;
	logic                        set_name;
	logic [LW-1:0]               set_len;
	logic                        mem_we;
	logic [7:0]                  nl_raw;
	logic [LW-1:0]               nl;
	logic [8:0]                  end_sum;
	logic [8:0]                  name_base;
	logic [7:0]                  idx;

	// emit
	logic [SW-1:0]               sel_s;
	logic                        sel_ok;
	logic                        emit_go;

	assign pop     = (state_q == S_IDLE) && head.valid;
	assign emit_go = (state_q == S_EMIT) && (!res_valid || res_ready);
	assign add_idx = count_q[SW-1:0];
	assign lk_add  = (state_q == S_LOOKUP) && !hit && (count_q < CW'(ME));

	always_comb begin
		for (int i = 0; i < ME; i++) begin
			match_d[i] = (CW'(i) < count_q) && (addr_q[i] == item_q.addr);
		end
	end

	always_comb begin
		hit     = |match_q;
		hit_idx = '0;
		for (int i = ME - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				hit_idx = SW'(i);
			end
		end
	end

	// one step of the AD structure walk on the current byte
	always_comb begin
		ph_d      = phase_q;
		sstart_d  = sstart_q;
		slen_d    = slen_q;
		set_name  = 1'b0;
		set_len   = '0;
		mem_we    = 1'b0;
		nl_raw    = slen_q - 8'd1;
		nl        = (nl_raw > {3'b0, bst_pkg::NAME_MAX}) ? bst_pkg::NAME_MAX : nl_raw[LW-1:0];
		end_sum   = {1'b0, sstart_q} + {1'b0, item_q.pbyte};
		name_base = {1'b0, sstart_q} + 9'd2;
		idx       = item_q.pos - sstart_q - 8'd2;
		if (phase_q != PH_IDLE && item_q.pos < item_q.plen) begin
			unique case (phase_q)
				PH_LEN: begin
					if (item_q.pos == sstart_q) begin
						if (item_q.pbyte == 8'd0 || end_sum >= {1'b0, item_q.plen}) begin
							ph_d = PH_IDLE;
						end else begin
							slen_d = item_q.pbyte;
							ph_d   = PH_TYPE;
						end
					end
				end
				PH_TYPE: begin
					if (item_q.pbyte == bst_pkg::AD_SHORT_NAME ||
					    item_q.pbyte == bst_pkg::AD_COMPLETE_NAME) begin
						if (slen_q == 8'd1) begin
							// empty name: named with zero length
							set_name = 1'b1;
							ph_d     = PH_IDLE;
						end else begin
							ph_d = PH_NAME;
						end
					end else begin
						sstart_d = sstart_q + slen_q + 8'd1;
						ph_d     = PH_LEN;
					end
				end
				PH_NAME: begin
					if ({1'b0, item_q.pos} >= name_base) begin
						mem_we = (idx < {3'b0, nl});
						if ({1'b0, idx} + 9'd1 >= {4'b0, nl}) begin
							set_name = 1'b1;
							set_len  = nl;
							ph_d     = PH_IDLE;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign sel_s  = (item_q.mode == bst_pkg::MODE_READ) ? item_q.rslot[SW-1:0] : cur_q;
	assign sel_ok = (item_q.mode == bst_pkg::MODE_READ) || (pend_q != bst_pkg::ST_DROPPED);

	// name bytes
	always_ff @(posedge clk) begin
		if (state_q == S_PARSE && mem_we) begin
			name_mem[{cur_q, idx[bst_pkg::NIDX_W-1:0]}] <= item_q.pbyte;
		end
		if (pop) begin
			mem_rd_q <= name_mem[{head.item.rslot[SW-1:0], head.item.ridx[bst_pkg::NIDX_W-1:0]}];
		end
	end

	// entry identity and rssi
	always_ff @(posedge clk) begin
		if (lk_add) begin
			addr_q[add_idx] <= item_q.addr;
			kind_q[add_idx] <= item_q.addr_kind;
			rssi_q[add_idx] <= item_q.rssi;
		end else if (state_q == S_LOOKUP && hit) begin
			rssi_q[hit_idx] <= item_q.rssi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_IDLE;
			item_q    <= '0;
			match_q   <= '0;
			count_q   <= '0;
			sstart_q  <= '0;
			slen_q    <= '0;
			cur_q     <= '0;
			pend_q    <= bst_pkg::ST_UPDATED;
			res_valid <= 1'b0;
			res       <= '0;
			for (int i = 0; i < ME; i++) begin
				named_q[i] <= 1'b0;
				nlen_q[i]  <= '0;
			end
		end else begin
			// a new result in the same cycle keeps the flag up
			if (res_valid && res_ready && !emit_go) begin
				res_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						item_q <= head.item;
						if (head.item.mode == bst_pkg::MODE_READ) begin
							state_q <= S_EMIT;
						end else if (head.item.first) begin
							state_q <= S_MATCH;
						end else begin
							state_q <= S_PARSE;
						end
					end
				end
				S_MATCH: begin
					match_q <= match_d;
					state_q <= S_LOOKUP;
				end
				S_LOOKUP: begin
					sstart_q <= '0;
					slen_q   <= '0;
					phase_q  <= PH_IDLE;
					if (hit) begin
						cur_q  <= hit_idx;
						pend_q <= bst_pkg::ST_UPDATED;
						if (!named_q[hit_idx] && item_q.plen != 8'd0) begin
							phase_q <= PH_LEN;
						end
					end else if (lk_add) begin
						named_q[add_idx] <= 1'b0;
						nlen_q[add_idx]  <= '0;
						count_q          <= count_q + 1'b1;
						cur_q            <= add_idx;
						pend_q           <= bst_pkg::ST_ADDED;
						if (item_q.plen != 8'd0) begin
							phase_q <= PH_LEN;
						end
					end else begin
						cur_q  <= '0;
						pend_q <= bst_pkg::ST_DROPPED;
					end
					state_q <= S_PARSE;
				end
				S_PARSE: begin
					if (set_name) begin
						named_q[cur_q] <= 1'b1;
						nlen_q[cur_q]  <= set_len;
					end
					if (item_q.last) begin
						phase_q  <= PH_IDLE;
						sstart_q <= '0;
						slen_q   <= '0;
						state_q  <= S_EMIT;
					end else begin
						phase_q  <= ph_d;
						sstart_q <= sstart_d;
						slen_q   <= slen_d;
						state_q  <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						res_valid <= 1'b1;
						// read-backs report status code zero
						res.status <= (item_q.mode == bst_pkg::MODE_READ) ?
						              bst_pkg::ST_UPDATED : pend_q;
						res.slot   <= 4'(sel_s);
						res.total  <= 5'(count_q);
						res.named  <= sel_ok ? named_q[sel_s] : 1'b0;
						res.nlen   <= sel_ok ? nlen_q[sel_s] : '0;
						res.addr   <= sel_ok ? addr_q[sel_s] : '0;
						res.addr_kind <= sel_ok ? kind_q[sel_s] : '0;
						res.rssi   <= sel_ok ? rssi_q[sel_s] : '0;
						res.nbyte  <= (item_q.mode == bst_pkg::MODE_READ && named_q[sel_s] &&
						               {3'b0, item_q.ridx} < {3'b0, nlen_q[sel_s]}) ?
						              mem_rd_q : 8'd0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/ble_scan_table_with_name_parse.sv =====
// Flow: the back end takes one queued item at a time and is back in idle before it
//   pops the next; a report's first byte passes a compare state and a lookup state
//   (address search) before its parse state, and its last byte goes on to an emit
//   state; a read-back goes from idle straight to emit. Input waits only on a full queue.
// Reset: arst_n clears the table count, name flags, walk state and queue at once;
//   no clearing pass, so the block is ready for transfers once reset is released.
module ble_scan_table_with_name_parse (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// dev_address[47:0] dev_address_kind[55:48] signal_level[63:56]
	// payload_length[71:64] payload_byte[79:72] read_slot[83:80] read_index[88:84]
	// zero fill [95:89]
	input  logic [bst_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// mode[0]
	input  logic                           s_axis_tuser,
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// report_status[1:0] slot[5:2] entry_total[10:6] name_known[11]
	// name_length[16:12] out_address[64:17] out_address_kind[72:65]
	// out_signal_level[80:73] name_byte[88:81] zero fill [95:89]
	output logic [bst_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	// Front end: takes input transfers, tags each report byte with its
	// position and marks the first byte of a report, which triggers the
	// table search in the back end.
	logic           q_full;
	logic           push;
	bst_pkg::item_t push_item;

	// Short queue so the front keeps taking bytes while the back end is
	// busy searching or waiting on a stalled output.
	logic           pop;
	bst_pkg::head_t head;

	// Back end: table search, entry update, AD structure walk, name store
	// and read-back, and the output register that parts it from downstream.
	logic             res_valid;
	bst_pkg::result_t res;

	bst_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.push          (push),
		.push_item     (push_item)
	);

	bst_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head      (head)
	);

	bst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	// Result transfer: pack fields from the lowest bit up.
	assign m_axis_tvalid = res_valid;
	assign m_axis_tdata  = {7'd0, res.nbyte, res.rssi, res.addr_kind, res.addr,
	                        res.nlen, res.named, res.total, res.slot, res.status};

endmodule

// ===== rtl/bst_checker.sv =====
module bst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata
);

	logic [1:0] status;
	logic [3:0] slot;
	logic [4:0] total;
	logic       named;
	logic [4:0] nlen;
	logic [7:0] nbyte;
	logic [4:0] last_total_q;

	assign status = m_axis_tdata[1:0];
	assign slot   = m_axis_tdata[5:2];
	assign total  = m_axis_tdata[10:6];
	assign named  = m_axis_tdata[11];
	assign nlen   = m_axis_tdata[16:12];
	assign nbyte  = m_axis_tdata[88:81];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_total_q <= '0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			last_total_q <= total;
		end
	end

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// entries are never removed
	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |-> total >= last_total_q && total <= 5'd16)
		else $error("entry total went backwards");

	// a report is dropped only on a full table, and shows no entry
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status == 2'd2 |-> total == 5'd16 && slot == 4'd0 && !named)
		else $error("drop with room in the table");

	// name data (a nonzero name byte or name length) only comes with a named entry
	a_name: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (nbyte != 8'd0 || nlen != 5'd0) |-> named)
		else $error("name data on an unnamed entry");

endmodule

bind ble_scan_table_with_name_parse bst_checker u_bst_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
